@@ hdl/dqc_pkg.sv @@
// shared types, codes and helpers for the debounced quadrature counter
package dqc_pkg;

	// field widths fixed by the item format
	localparam int AB_W      = 2;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int STEPS_W   = 16;
	localparam int RETRY_W   = 8;
	localparam int DEG_W     = 25;
	localparam int MICRO_W   = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// arithmetic constants
	localparam int DEG_PER_TURN    = 360;
	localparam int MICRO_PER_UNIT  = 1000000;
	localparam int DEG_CONST_W     = 9;
	localparam int MICRO_CONST_W   = 20;
	localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STS_COLLECT    = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DONE       = 3'd1;
	localparam logic [STATUS_W-1:0] STS_READ_OK    = 3'd2;
	localparam logic [STATUS_W-1:0] STS_IGNORED    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_STEPS_ZERO = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 2'd1;

	// direction codes
	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_UP   = 2'sd1;
	localparam logic signed [1:0] DIR_DOWN = -2'sd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAJ,
		S_MUL1,
		S_DIV1_GO,
		S_DIV1,
		S_MUL2,
		S_DIV2_GO,
		S_DIV2,
		S_PUT
	} seq_state_t;

	// detent rule: direction of a move from prev to cur
	function automatic logic signed [1:0] dir_of(input logic [AB_W-1:0] prev,
		input logic [AB_W-1:0] cur);
		logic signed [1:0] d;
		d = DIR_NONE;
		if (prev == cur) begin
			d = DIR_NONE;
		end else if ((prev == 2'd0 && cur == 2'd3) ||
			(cur == 2'd0 && (prev == 2'd1 || prev == 2'd2))) begin
			d = DIR_UP;
		end else if ((prev == 2'd3 && cur == 2'd0) ||
			(cur == 2'd3 && (prev == 2'd1 || prev == 2'd2))) begin
			d = DIR_DOWN;
		end
		return d;
	endfunction

endpackage

@@ hdl/dqc_divider.sv @@
// serial restoring divider, one quotient bit per cycle
module dqc_divider #(
	parameter int DIV_W = 41
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIV_W-1:0]            dividend,
	input  logic [dqc_pkg::STEPS_W-1:0] divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            quotient,
	output logic [dqc_pkg::STEPS_W-1:0] remainder
);
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int SW    = dqc_pkg::STEPS_W;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    quo_q;
	logic [SW-1:0]       rem_q;
	logic [SW-1:0]       dvs_q;
	logic [SW:0]         trial;
	logic [SW:0]         diff;
	logic                fits;
	logic [SW-1:0]       rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DIV_W-1]};
		diff    = trial - {1'b0, dvs_q};
		fits    = (trial >= {1'b0, dvs_q});
		rem_nxt = fits ? diff[SW-1:0] : trial[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ hdl/debounced_quadrature_counter.sv @@
// top level of the debounced quadrature counter
//
// input channel (in_valid / in_stall): one transaction per request, req_type
//   selects start window, pin sample or read rotation; ab_pins holds A in bit 1
//   and B in bit 0. in_stall is high while a request is being worked on.
// output channel (out_valid / out_stall): exactly one result transaction per
//   request, in order. the result sits in an output register, so a new request
//   is taken while the previous result still waits on a stalled receiver.
// config channel (cfg_valid / cfg_ready): cfg_index 0 writes steps_per_turn,
//   1 writes retry_limit; other indexes are dropped. write only while idle.
// sequence: start, sample, ignored and steps-zero requests go from idle straight
//   to the put step; a sample that fills the window passes the majority step
//   first. a read passes two multiply steps and two divide steps, as the serial
//   divider (DIV_W = max(PULSE_BITS + 9, 36)) runs once for the degrees and
//   once for the micro-degree fraction, one quotient bit per cycle.
// flow: one request at a time; the next is accepted once the previous result
//   is in the output register.
// reset: window closed, tallies and pulse counter cleared, stored state 0,
//   steps_per_turn 0, retry_limit 3, no result pending.
module debounced_quadrature_counter #(
	parameter int WINDOW_SAMPLES = 5,
	parameter int PULSE_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dqc_pkg::REQ_W-1:0]           req_type,
	input  logic [dqc_pkg::AB_W-1:0]            ab_pins,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dqc_pkg::STATUS_W-1:0]        status,
	output logic                                busy_res,
	output logic signed [1:0]                   delta,
	output logic [dqc_pkg::AB_W-1:0]            ab_now,
	output logic signed [dqc_pkg::DEG_W-1:0]    degrees,
	output logic signed [dqc_pkg::MICRO_W-1:0]  micro_degrees,
	// config channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dqc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dqc_pkg::CFG_DAT_W-1:0]       cfg_data
);
	localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
	localparam int PROD_W = PULSE_BITS + dqc_pkg::DEG_CONST_W;
	localparam int FRAC_W = dqc_pkg::STEPS_W + dqc_pkg::MICRO_CONST_W;
	localparam int DIV_W  = (PROD_W > FRAC_W) ? PROD_W : FRAC_W;
	localparam int AB_W   = dqc_pkg::AB_W;
	localparam int RW     = dqc_pkg::RETRY_W;

	localparam logic signed [PULSE_BITS-1:0] PULSE_MAX = {1'b0, {(PULSE_BITS-1){1'b1}}};
	localparam logic signed [PULSE_BITS-1:0] PULSE_MIN = {1'b1, {(PULSE_BITS-1){1'b0}}};

	dqc_pkg::seq_state_t state_q, state_nxt;

	// configuration
	logic [dqc_pkg::STEPS_W-1:0] steps_q;
	logic [RW-1:0]               retry_limit_q;

	// encoder state
	logic [AB_W-1:0]               last_ab_q;
	logic [CNT_W-1:0]              tally_q [4];
	logic [CNT_W-1:0]              count_q;
	logic                          win_open_q;
	logic                          retry_q;
	logic [RW-1:0]                 retries_q;
	logic signed [PULSE_BITS-1:0]  pulse_q;

	// result being built
	logic [dqc_pkg::STATUS_W-1:0]       res_status_q;
	logic signed [1:0]                  res_delta_q;
	logic signed [dqc_pkg::DEG_W-1:0]   res_deg_q;
	logic signed [dqc_pkg::MICRO_W-1:0] res_micro_q;

	// read arithmetic
	logic [DIV_W-1:0] num_q;
	logic             neg_q;

	// output register
	logic                               out_valid_q;
	logic [dqc_pkg::STATUS_W-1:0]       status_q;
	logic                               busy_q;
	logic signed [1:0]                  delta_q;
	logic [AB_W-1:0]                    ab_now_q;
	logic signed [dqc_pkg::DEG_W-1:0]   deg_q;
	logic signed [dqc_pkg::MICRO_W-1:0] micro_q;

	// sequencer controls
	logic accept;
	logic div_start;
	logic out_load;

	// divider
	logic                        div_done;
	logic [DIV_W-1:0]            div_quo;
	logic [dqc_pkg::STEPS_W-1:0] div_rem;

	// window close logic
	logic                          win_full;
	logic [RW:0]                   retry_next;
	logic [AB_W-1:0]               best_ab;
	logic [CNT_W-1:0]              best_cnt;
	logic                          fin_en;
	logic [AB_W-1:0]               fin_ab;
	logic signed [1:0]             fin_dir;
	logic signed [PULSE_BITS:0]    pulse_sum;
	logic signed [PULSE_BITS-1:0]  pulse_sat;
	logic [PULSE_BITS-1:0]         pulse_mag;

	assign accept = in_valid && !in_stall;

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dqc_pkg::S_IDLE: begin
				if (accept) begin
					state_nxt = dqc_pkg::S_PUT;
					if (req_type == dqc_pkg::REQ_SAMPLE && win_open_q && !retry_q &&
						win_full) begin
						state_nxt = dqc_pkg::S_MAJ;
					end else if (req_type == dqc_pkg::REQ_READ && steps_q != '0) begin
						state_nxt = dqc_pkg::S_MUL1;
					end
				end
			end
			dqc_pkg::S_MAJ:     state_nxt = dqc_pkg::S_PUT;
			dqc_pkg::S_MUL1:    state_nxt = dqc_pkg::S_DIV1_GO;
			dqc_pkg::S_DIV1_GO: state_nxt = dqc_pkg::S_DIV1;
			dqc_pkg::S_DIV1: begin
				if (div_done) begin
					state_nxt = dqc_pkg::S_MUL2;
				end
			end
			dqc_pkg::S_MUL2:    state_nxt = dqc_pkg::S_DIV2_GO;
			dqc_pkg::S_DIV2_GO: state_nxt = dqc_pkg::S_DIV2;
			dqc_pkg::S_DIV2: begin
				if (div_done) begin
					state_nxt = dqc_pkg::S_PUT;
				end
			end
			dqc_pkg::S_PUT: begin
				if (out_load) begin
					state_nxt = dqc_pkg::S_IDLE;
				end
			end
			default: state_nxt = dqc_pkg::S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			dqc_pkg::S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			dqc_pkg::S_DIV1_GO, dqc_pkg::S_DIV2_GO: begin
				div_start = 1'b1;
			end
			dqc_pkg::S_PUT: begin
				// result register free, or its contents leave this cycle
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------------------------------------------------------- majority and close
	always_comb begin
		best_ab  = '0;
		best_cnt = '0;
		// strict compare keeps the lowest state on a tie
		for (int i = 0; i < 4; i++) begin
			if (tally_q[i] > best_cnt) begin
				best_cnt = tally_q[i];
				best_ab  = AB_W'(i);
			end
		end
	end

	assign win_full   = (count_q + 1'b1) == CNT_W'(WINDOW_SAMPLES);
	assign retry_next = {1'b0, retries_q} + 1'b1;

	always_comb begin
		fin_en = 1'b0;
		fin_ab = best_ab;
		if (state_q == dqc_pkg::S_MAJ) begin
			fin_en = (best_ab != last_ab_q) || (retry_limit_q == '0);
		end else if (accept && req_type == dqc_pkg::REQ_SAMPLE && win_open_q && retry_q) begin
			// retry sample: first change or the last allowed retry closes the window
			fin_ab = ab_pins;
			fin_en = (ab_pins != last_ab_q) || (retry_next >= {1'b0, retry_limit_q});
		end
	end

	// saturating pulse update
	always_comb begin
		fin_dir   = dqc_pkg::dir_of(last_ab_q, fin_ab);
		pulse_sum = {pulse_q[PULSE_BITS-1], pulse_q} +
			{{(PULSE_BITS-1){fin_dir[1]}}, fin_dir};
		if (pulse_sum[PULSE_BITS] != pulse_sum[PULSE_BITS-1]) begin
			pulse_sat = pulse_sum[PULSE_BITS] ? PULSE_MIN : PULSE_MAX;
		end else begin
			pulse_sat = pulse_sum[PULSE_BITS-1:0];
		end
		pulse_mag = pulse_q[PULSE_BITS-1] ? (PULSE_BITS)'(-pulse_q) : pulse_q;
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q       <= '0;
			retry_limit_q <= dqc_pkg::RETRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dqc_pkg::CFG_STEPS: steps_q       <= cfg_data;
				dqc_pkg::CFG_RETRY: retry_limit_q <= cfg_data[RW-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q  <= '0;
			count_q    <= '0;
			win_open_q <= 1'b0;
			retry_q    <= 1'b0;
			retries_q  <= '0;
			pulse_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				case (req_type)
					dqc_pkg::REQ_START: begin
						// restart: any open window is dropped
						win_open_q <= 1'b1;
						retry_q    <= 1'b0;
						retries_q  <= '0;
						count_q    <= '0;
						for (int i = 0; i < 4; i++) begin
							tally_q[i] <= '0;
						end
					end
					dqc_pkg::REQ_SAMPLE: begin
						if (win_open_q && retry_q) begin
							retries_q <= retry_next[RW-1:0];
						end else if (win_open_q) begin
							tally_q[ab_pins] <= tally_q[ab_pins] + 1'b1;
							count_q          <= count_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == dqc_pkg::S_MAJ && !fin_en) begin
				// majority matches stored state: go try a few more samples
				retry_q   <= 1'b1;
				retries_q <= '0;
			end
			if (state_q == dqc_pkg::S_MUL1) begin
				pulse_q <= '0;
			end
			if (fin_en) begin
				pulse_q    <= pulse_sat;
				last_ab_q  <= fin_ab;
				win_open_q <= 1'b0;
				retry_q    <= 1'b0;
				retries_q  <= '0;
				count_q    <= '0;
				for (int i = 0; i < 4; i++) begin
					tally_q[i] <= '0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result build
	always_ff @(posedge clk) begin
		if (accept) begin
			res_delta_q <= dqc_pkg::DIR_NONE;
			res_deg_q   <= '0;
			res_micro_q <= '0;
			case (req_type)
				dqc_pkg::REQ_START: res_status_q <= dqc_pkg::STS_COLLECT;
				dqc_pkg::REQ_SAMPLE: begin
					res_status_q <= win_open_q ? dqc_pkg::STS_COLLECT : dqc_pkg::STS_IGNORED;
				end
				dqc_pkg::REQ_READ: begin
					res_status_q <= (steps_q == '0) ? dqc_pkg::STS_STEPS_ZERO :
						dqc_pkg::STS_READ_OK;
				end
				default: res_status_q <= dqc_pkg::STS_IGNORED;
			endcase
		end
		if (fin_en) begin
			res_status_q <= dqc_pkg::STS_DONE;
			res_delta_q  <= fin_dir;
		end
		case (state_q)
			dqc_pkg::S_MUL1: begin
				// magnitude times 360, sign handled after the divides
				neg_q <= pulse_q[PULSE_BITS-1];
				num_q <= DIV_W'(pulse_mag) * DIV_W'(dqc_pkg::DEG_PER_TURN);
			end
			dqc_pkg::S_DIV1: begin
				if (div_done) begin
					res_deg_q <= neg_q ? -div_quo[dqc_pkg::DEG_W-1:0] :
						div_quo[dqc_pkg::DEG_W-1:0];
				end
			end
			dqc_pkg::S_MUL2: begin
				num_q <= DIV_W'(div_rem) * DIV_W'(dqc_pkg::MICRO_PER_UNIT);
			end
			dqc_pkg::S_DIV2: begin
				if (div_done) begin
					res_micro_q <= neg_q ? -div_quo[dqc_pkg::MICRO_W-1:0] :
						div_quo[dqc_pkg::MICRO_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	dqc_divider #(
		.DIV_W(DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (num_q),
		.divisor   (steps_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status_q;
			busy_q   <= win_open_q;
			delta_q  <= res_delta_q;
			ab_now_q <= last_ab_q;
			deg_q    <= res_deg_q;
			micro_q  <= res_micro_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign busy_res      = busy_q;
	assign delta         = delta_q;
	assign ab_now        = ab_now_q;
	assign degrees       = deg_q;
	assign micro_degrees = micro_q;

	// ---------------------------------------------------------------- checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request taken while a previous one is still open");

	a_retry_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		retry_q |-> win_open_q)
		else $error("retry phase without an open window");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!win_open_q |-> (count_q == '0 && retries_q == '0))
		else $error("closed window left sample or retry count behind");

	a_div_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == dqc_pkg::S_DIV1 || state_q == dqc_pkg::S_DIV2))
		else $error("divider finished outside a divide step");

	a_pulse_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqc_pkg::S_MUL1 |=> pulse_q == '0)
		else $error("pulse counter not cleared by a read");

endmodule
